[hdl/tagged_block_stream_parser_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the tagged block stream parser
// Expect clk and arst_n in the scope where a macro is used.
// ---------------------------------------------------------------------------
`ifndef TAGGED_BLOCK_STREAM_PARSER_MACROS_SVH
`define TAGGED_BLOCK_STREAM_PARSER_MACROS_SVH

// Check an implication on every clock edge outside of reset.
`define TBSP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition never holds outside of reset.
`define TBSP_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

[hdl/tbsp_pkg.sv]
// ---------------------------------------------------------------------------
// Tagged block stream parser package
// Parse phases, marker bit positions, result kinds and the result record.
// ---------------------------------------------------------------------------
package tbsp_pkg;

	typedef enum logic [2:0] {
		PH_MARKER  = 3'd0,
		PH_TIME    = 3'd1,
		PH_SIZE    = 3'd2,
		PH_TYPE    = 3'd3,
		PH_ENTITY  = 3'd4,
		PH_CONTENT = 3'd5
	} phase_t;

	// Marker flags are numbered from the MSB: flag n sits at bit 7 - n.
	localparam int unsigned MARK_TIME_DELTA   = 7 - 0;
	localparam int unsigned MARK_NO_TYPE      = 7 - 1;
	localparam int unsigned MARK_ENTITY_DELTA = 7 - 2;
	localparam int unsigned MARK_SHORT_SIZE   = 7 - 3;

	localparam logic KIND_HEADER  = 1'b0;
	localparam logic KIND_CONTENT = 1'b1;

	localparam logic [1:0] LAST_FIELD_BYTE = 2'd3;

	typedef struct packed {
		logic        valid;
		logic        kind;
		logic [7:0]  content_byte;
		logic [31:0] base_time_bits;
		logic [31:0] offset_ms;
		logic [7:0]  block_type;
		logic [31:0] entity_id;
		logic [31:0] content_size;
		logic        last_of_block;
	} result_t;

endpackage

[hdl/tagged_block_stream_parser.sv]
// ---------------------------------------------------------------------------
// Tagged block stream parser
// Splits a byte stream of marker-tagged blocks into header and content results.
// ---------------------------------------------------------------------------
// Usage:
//   Slave side takes one stream byte per transfer in s_tdata; s_tuser high
//   clears all running values and makes the byte a new block marker.
//   Master side gives one result per header and one per content byte:
//   m_tuser is the kind (0 header, 1 content), m_tlast marks the last
//   result of a block (the header itself when the block has no content).
//   Marker, time, size, type and partial entity bytes give no result.
// Path: the byte that causes a result passes the input register, then the
//   result register, before the result is presented; a stall may hold it.
// Throughput: one byte per cycle while no waiting result is held by a low
//   m_tready; the state update of the parser core between the registers sets this.
// Reset: arst_n clears the parse state and the valid flags of both
//   registers; the first byte after reset is taken as a marker.
// Stall: while m_tready is low a waiting result holds, one more byte may sit
//   in the input register, and s_tready then drops until the result goes.
// ---------------------------------------------------------------------------
module tagged_block_stream_parser (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,  // [7:0] data_byte
	input  logic         s_tuser,  // [0] restart
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [143:0] m_tdata,  // [7:0] content_byte, [39:8] base_time_bits,
	                               // [71:40] offset_ms, [79:72] block_type,
	                               // [111:80] entity_id, [143:112] content_size
	output logic         m_tuser,  // [0] kind
	output logic         m_tlast   // last_of_block
);
	import tbsp_pkg::*;

	logic       valid_s1;
	logic [7:0] data_s1;
	logic       restart_s1;
	logic       m_valid_q;
	result_t    res_q;
	result_t    core_res;
	logic       advance;

	// Move the held byte on whenever the result register is free or draining.
	assign advance  = !m_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			data_s1    <= s_tdata;
			restart_s1 <= s_tuser;
		end
	end

	tbsp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (valid_s1 && advance),
		.data_byte (data_s1),
		.restart   (restart_s1),
		.res       (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= valid_s1 && core_res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && core_res.valid) begin
			res_q <= core_res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = res_q.kind;
	assign m_tlast  = res_q.last_of_block;
	assign m_tdata  = {res_q.content_size, res_q.entity_id, res_q.block_type,
		res_q.offset_ms, res_q.base_time_bits, res_q.content_byte};

endmodule

[hdl/tbsp_core.sv]
// ---------------------------------------------------------------------------
// Tagged block stream parser core
// Holds the parse state and turns one stream byte into at most one result.
// ---------------------------------------------------------------------------
`include "tagged_block_stream_parser_macros.svh"

module tbsp_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        data_byte,
	input  logic              restart,
	output tbsp_pkg::result_t res
);
	import tbsp_pkg::*;

	phase_t      phase_q, phase_d;
	logic [1:0]  count_q, count_d;
	logic [7:0]  marker_q, marker_d;
	logic [31:0] word_q, word_d;
	logic [31:0] base_q, base_d;
	logic [31:0] offset_q, offset_d;
	logic [7:0]  type_q, type_d;
	logic [31:0] entity_q, entity_d;
	logic [31:0] size_q, size_d;
	logic [31:0] remain_q, remain_d;

	phase_t      ph;
	logic [1:0]  cnt;
	logic [7:0]  mk;
	logic [31:0] wd, bt, ofs, ent, sz, rem;
	logic [7:0]  ty;
	logic [31:0] collected;
	logic        field_done;
	logic [32:0] ofs_sum;
	logic [31:0] rem_dec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_MARKER;
			count_q  <= '0;
			marker_q <= '0;
			word_q   <= '0;
			base_q   <= '0;
			offset_q <= '0;
			type_q   <= '0;
			entity_q <= '0;
			size_q   <= '0;
			remain_q <= '0;
		end else if (step) begin
			phase_q  <= phase_d;
			count_q  <= count_d;
			marker_q <= marker_d;
			word_q   <= word_d;
			base_q   <= base_d;
			offset_q <= offset_d;
			type_q   <= type_d;
			entity_q <= entity_d;
			size_q   <= size_d;
			remain_q <= remain_d;
		end
	end

	always_comb begin
		// Restart clears everything first; the byte is then a marker.
		ph  = restart ? PH_MARKER : phase_q;
		cnt = restart ? 2'd0 : count_q;
		mk  = restart ? 8'd0 : marker_q;
		wd  = restart ? 32'd0 : word_q;
		bt  = restart ? 32'd0 : base_q;
		ofs = restart ? 32'd0 : offset_q;
		ty  = restart ? 8'd0 : type_q;
		ent = restart ? 32'd0 : entity_q;
		sz  = restart ? 32'd0 : size_q;
		rem = restart ? 32'd0 : remain_q;
		if (ph == PH_CONTENT && rem == 32'd0) begin
			ph = PH_MARKER;
		end

		// Little-endian assembly: byte cnt lands at bits 8*cnt.
		collected  = (cnt == 2'd0) ? 32'd0 : wd;
		collected  = collected | (32'(data_byte) << {cnt, 3'b000});
		field_done = (cnt == LAST_FIELD_BYTE);
		ofs_sum    = {1'b0, ofs} + {25'd0, data_byte};
		rem_dec    = rem - 32'd1;

		phase_d  = ph;
		count_d  = cnt;
		marker_d = mk;
		word_d   = wd;
		base_d   = bt;
		offset_d = ofs;
		type_d   = ty;
		entity_d = ent;
		size_d   = sz;
		remain_d = rem;
		res      = '0;

		unique case (ph)
			PH_MARKER: begin
				marker_d = data_byte;
				count_d  = 2'd0;
				word_d   = 32'd0;
				phase_d  = PH_TIME;
			end
			PH_TIME: begin
				if (!mk[MARK_TIME_DELTA]) begin
					word_d  = collected;
					count_d = cnt + 2'd1;
					if (field_done) begin
						base_d   = collected;
						offset_d = 32'd0;
						phase_d  = PH_SIZE;
					end
				end else begin
					offset_d = ofs_sum[32] ? 32'hFFFF_FFFF : ofs_sum[31:0];
					phase_d  = PH_SIZE;
				end
			end
			PH_SIZE: begin
				if (!mk[MARK_SHORT_SIZE]) begin
					word_d  = collected;
					count_d = cnt + 2'd1;
					if (field_done) begin
						size_d  = collected;
						phase_d = mk[MARK_NO_TYPE] ? PH_ENTITY : PH_TYPE;
					end
				end else begin
					size_d  = 32'(data_byte);
					phase_d = mk[MARK_NO_TYPE] ? PH_ENTITY : PH_TYPE;
				end
			end
			PH_TYPE: begin
				type_d  = data_byte;
				phase_d = PH_ENTITY;
			end
			PH_ENTITY: begin
				if (!mk[MARK_ENTITY_DELTA]) begin
					word_d  = collected;
					count_d = cnt + 2'd1;
				end
				if (mk[MARK_ENTITY_DELTA] || field_done) begin
					entity_d = mk[MARK_ENTITY_DELTA] ? ent + 32'(data_byte) : collected;
					remain_d = sz;
					phase_d  = (sz == 32'd0) ? PH_MARKER : PH_CONTENT;
					res.valid         = 1'b1;
					res.kind          = KIND_HEADER;
					res.content_byte  = 8'd0;
					res.last_of_block = (sz == 32'd0);
				end
			end
			PH_CONTENT: begin
				remain_d = rem_dec;
				if (rem_dec == 32'd0) begin
					phase_d = PH_MARKER;
				end
				res.valid         = 1'b1;
				res.kind          = KIND_CONTENT;
				res.content_byte  = data_byte;
				res.last_of_block = (rem_dec == 32'd0);
			end
			default: begin
				phase_d = PH_MARKER;
			end
		endcase

		res.base_time_bits = base_d;
		res.offset_ms      = offset_d;
		res.block_type     = type_d;
		res.entity_id      = entity_d;
		res.content_size   = size_d;
	end

	`TBSP_ASSERT(a_last_ends_block,
		step && res.valid && res.last_of_block |=> phase_q == PH_MARKER,
		"block did not end after its last result")
	`TBSP_ASSERT(a_header_last_size,
		res.valid && res.kind == KIND_HEADER
			|-> res.last_of_block == (res.content_size == 32'd0),
		"header last flag disagrees with size")
	`TBSP_ASSERT(a_content_in_phase,
		res.valid && res.kind == KIND_CONTENT
			|-> !restart && phase_q == PH_CONTENT && remain_q != 32'd0,
		"content result outside content phase")
	`TBSP_NEVER(a_content_no_wrap,
		step && phase_q == PH_CONTENT && !restart && remain_d == 32'hFFFF_FFFF,
		"remaining content count wrapped")

endmodule
